/* rtl/hqp_pkg.sv */
package hqp_pkg;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_EXHAUSTED = 3'd4
	} status_t;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	// floor(((sqrt(5)-1)/2) * 2^32)
	localparam logic [31:0] GOLDEN_FRAC32 = 32'h9E3779B9;

	localparam int KEY_W = 31;
	localparam int VAL_W = 32;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] found_value;
		logic [3:0]         slot;
	} res_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_CALC,
		FR_PUSH
	} fr_state_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_RUN,
		BK_DONE
	} bk_state_t;

endpackage

/* rtl/hqp_ram.sv */
module hqp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/hqp_queue.sv */
module hqp_queue #(
	parameter int WIDTH = 73
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/hqp_front.sv */
module hqp_front #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 hold,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic                                 s_tuser,
	input  logic [63:0]                          s_tdata,
	output logic                                 push_valid,
	input  logic                                 push_ready,
	output logic [2*$clog2(TABLE_SLOTS)+64:0]    push_data
);

	localparam int SW = $clog2(TABLE_SLOTS);
	localparam logic [SW:0] SLOTS_W = (SW+1)'(TABLE_SLOTS);

	hqp_pkg::fr_state_t state_q, state_d;
	logic [2:0]    step_q;
	logic          kind_q;
	logic [30:0]   key_q;
	logic [31:0]   val_q;
	logic          zero_q;
	logic [31:0]   ksh_q;
	logic [31:0]   frac_q;
	logic [SW-1:0] home_q;
	logic [SW-1:0] r_q;
	logic [63:0]   hprod;
	logic          accept;

	// key mod slots, four key bits a step, MSB first
	function automatic logic [SW-1:0] mod_step(input logic [SW-1:0] r_in,
			input logic [3:0] nib);
		logic [SW:0]   t;
		logic [SW-1:0] r;
		r = r_in;
		for (int j = 3; j >= 0; j--) begin
			t = {r, nib[j]};
			if (t >= SLOTS_W) begin
				t = t - SLOTS_W;
			end
			r = t[SW-1:0];
		end
		return r;
	endfunction

	assign hprod  = {32'b0, frac_q} * 64'(TABLE_SLOTS);
	assign accept = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			hqp_pkg::FR_IDLE: begin
				if (accept) state_d = hqp_pkg::FR_CALC;
			end
			hqp_pkg::FR_CALC: begin
				if (step_q == 3'd7) state_d = hqp_pkg::FR_PUSH;
			end
			hqp_pkg::FR_PUSH: begin
				if (push_ready) state_d = hqp_pkg::FR_IDLE;
			end
			default: state_d = hqp_pkg::FR_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == hqp_pkg::FR_IDLE) && !hold;
		push_valid = (state_q == hqp_pkg::FR_PUSH);
		push_data  = {r_q, home_q, zero_q, val_q, key_q, kind_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hqp_pkg::FR_IDLE;
			step_q  <= 3'd0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= 3'd0;
			end else if (state_q == hqp_pkg::FR_CALC) begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser;
			key_q  <= s_tdata[30:0];
			val_q  <= s_tdata[62:31];
			zero_q <= (s_tdata[30:0] == 31'd0);
			ksh_q  <= {1'b0, s_tdata[30:0]};
			r_q    <= '0;
		end else if (state_q == hqp_pkg::FR_CALC) begin
			ksh_q <= {ksh_q[27:0], 4'b0};
			r_q   <= mod_step(r_q, ksh_q[31:28]);
			if (step_q == 3'd0) begin
				frac_q <= {1'b0, key_q} * hqp_pkg::GOLDEN_FRAC32;
			end
			if (step_q == 3'd1) begin
				home_q <= hprod[32 +: SW];
			end
		end
	end

endmodule

/* rtl/hqp_back.sv */
module hqp_back #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	output logic                              clearing,
	input  logic                              q_valid,
	output logic                              q_pop,
	input  logic [2*$clog2(TABLE_SLOTS)+64:0] q_data,
	output logic                              m_valid,
	input  logic                              m_ready,
	output hqp_pkg::res_t                     m_res
);

	localparam int SW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 2);
	localparam logic [SW:0]   SLOTS_W = (SW+1)'(TABLE_SLOTS);
	localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);

	hqp_pkg::bk_state_t state_q, state_d;

	logic          q_kind;
	logic [30:0]   q_key;
	logic [31:0]   q_val;
	logic          q_zero;
	logic [SW-1:0] q_home;
	logic [SW-1:0] q_kmod;
	logic          q_short;

	logic [SW-1:0] clr_q;
	logic          kind_q;
	logic [30:0]   key_q;
	logic [31:0]   val_q;
	logic [SW-1:0] home_q;
	logic          first_q;
	logic          iss_q;
	logic [CW-1:0] cand_q;
	logic [CW-1:0] lim_q;
	logic [SW-1:0] gp_q;
	logic [SW-1:0] gd_q;
	logic [CW-1:0] gi_q;
	logic          rd_vld_s1;
	logic [SW-1:0] rd_slot_s1;
	logic [CW-1:0] rd_i_s1;
	logic          rd_last_s1;
	logic [CW-1:0] count_q;
	logic [CW-1:0] max_probe_q;
	hqp_pkg::res_t res_q;
	hqp_pkg::res_t m_q;
	logic          m_vld_q;

	logic [SW-1:0] iss_addr;
	logic [SW:0]   gp_sum;
	logic [SW:0]   gd_sum;
	logic [SW-1:0] gp_nx;
	logic [SW-1:0] gd_nx;
	logic          hit;
	logic          stop;
	logic          ins_hit;
	logic          issue;
	logic          m_load;
	logic          clr_last;

	logic          key_we;
	logic [SW-1:0] key_waddr;
	logic [30:0]   key_wdata;
	logic [30:0]   key_rdata;
	logic [31:0]   val_rdata;

	assign q_kind = q_data[0];
	assign q_key  = q_data[31:1];
	assign q_val  = q_data[63:32];
	assign q_zero = q_data[64];
	assign q_home = q_data[65 +: SW];
	assign q_kmod = q_data[65+SW +: SW];
	// answered without touching the table
	assign q_short = q_zero || (q_kind == hqp_pkg::KIND_INSERT && count_q >= SLOTS_C);

	// next probe slot: p(i+1) = p(i) + (2i+1), all mod slots
	assign gp_sum = {1'b0, gp_q} + {1'b0, gd_q};
	assign gd_sum = {1'b0, gd_q} + (SW+1)'(2);
	assign gp_nx  = (gp_sum >= SLOTS_W) ? SW'(gp_sum - SLOTS_W) : gp_sum[SW-1:0];
	assign gd_nx  = (gd_sum >= SLOTS_W) ? SW'(gd_sum - SLOTS_W) : gd_sum[SW-1:0];

	assign iss_addr = first_q ? home_q : gp_q;
	assign hit      = rd_vld_s1 && ((kind_q == hqp_pkg::KIND_INSERT) ?
		(key_rdata == 31'd0) : (key_rdata == key_q));
	assign stop     = rd_vld_s1 && (hit || rd_last_s1);
	assign ins_hit  = hit && (kind_q == hqp_pkg::KIND_INSERT);
	assign clr_last = (clr_q == SW'(TABLE_SLOTS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			hqp_pkg::BK_CLEAR: begin
				if (clr_last) state_d = hqp_pkg::BK_IDLE;
			end
			hqp_pkg::BK_IDLE: begin
				if (q_valid) state_d = q_short ? hqp_pkg::BK_DONE : hqp_pkg::BK_RUN;
			end
			hqp_pkg::BK_RUN: begin
				if (stop) state_d = hqp_pkg::BK_DONE;
			end
			hqp_pkg::BK_DONE: begin
				if (!m_vld_q || m_ready) state_d = hqp_pkg::BK_IDLE;
			end
			default: state_d = hqp_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		clearing  = (state_q == hqp_pkg::BK_CLEAR);
		q_pop     = (state_q == hqp_pkg::BK_IDLE) && q_valid;
		issue     = (state_q == hqp_pkg::BK_RUN) && iss_q && !stop;
		m_load    = (state_q == hqp_pkg::BK_DONE) && (!m_vld_q || m_ready);
		key_we    = clearing || ins_hit;
		key_waddr = clearing ? clr_q : rd_slot_s1;
		key_wdata = clearing ? 31'd0 : key_q;
		m_valid   = m_vld_q;
		m_res     = m_q;
	end

	hqp_ram #(
		.WIDTH (hqp_pkg::KEY_W),
		.DEPTH (TABLE_SLOTS)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.raddr (iss_addr),
		.rdata (key_rdata)
	);

	hqp_ram #(
		.WIDTH (hqp_pkg::VAL_W),
		.DEPTH (TABLE_SLOTS)
	) u_val_ram (
		.clk   (clk),
		.we    (ins_hit),
		.waddr (rd_slot_s1),
		.wdata (val_q),
		.raddr (iss_addr),
		.rdata (val_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hqp_pkg::BK_CLEAR;
			clr_q       <= '0;
			iss_q       <= 1'b0;
			rd_vld_s1   <= 1'b0;
			count_q     <= '0;
			max_probe_q <= '0;
			m_vld_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + SW'(1);
			end
			if (q_pop) begin
				iss_q <= !q_short;
			end else if (stop || (issue && cand_q == lim_q)) begin
				iss_q <= 1'b0;
			end
			rd_vld_s1 <= issue;
			if (ins_hit) begin
				count_q <= count_q + CW'(1);
				if (rd_i_s1 > max_probe_q) begin
					max_probe_q <= rd_i_s1;
				end
			end
			if (m_load) begin
				m_vld_q <= 1'b1;
			end else if (m_ready) begin
				m_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q  <= q_kind;
			key_q   <= q_key;
			val_q   <= q_val;
			home_q  <= q_home;
			first_q <= 1'b1;
			cand_q  <= '0;
			gp_q    <= q_kmod;
			gd_q    <= SW'(1);
			gi_q    <= '0;
			lim_q   <= (q_kind == hqp_pkg::KIND_INSERT) ? SLOTS_C : CW'(max_probe_q + CW'(1));
			res_q.found_value <= '0;
			res_q.slot        <= '0;
			res_q.status      <= q_zero ? hqp_pkg::ST_NOT_FOUND : hqp_pkg::ST_FULL;
		end
		if (issue) begin
			rd_slot_s1 <= iss_addr;
			rd_i_s1    <= first_q ? CW'(0) : gi_q;
			rd_last_s1 <= (cand_q == lim_q);
			cand_q     <= cand_q + CW'(1);
			first_q    <= 1'b0;
			// insert skips p(0): the home read already stands for it
			if (!first_q || kind_q == hqp_pkg::KIND_INSERT) begin
				gp_q <= gp_nx;
				gd_q <= gd_nx;
				gi_q <= gi_q + CW'(1);
			end
		end
		if (stop) begin
			if (ins_hit) begin
				res_q.status      <= hqp_pkg::ST_INSERTED;
				res_q.found_value <= '0;
				res_q.slot        <= 4'(rd_slot_s1);
			end else if (hit) begin
				res_q.status      <= hqp_pkg::ST_FOUND;
				res_q.found_value <= val_rdata;
				res_q.slot        <= 4'(rd_slot_s1);
			end else begin
				res_q.status      <= (kind_q == hqp_pkg::KIND_INSERT) ?
					hqp_pkg::ST_EXHAUSTED : hqp_pkg::ST_NOT_FOUND;
				res_q.found_value <= '0;
				res_q.slot        <= '0;
			end
		end
		if (m_load) begin
			m_q <= res_q;
		end
	end

endmodule

/* rtl/hash_table_quadratic_probe_top.sv */
// Channel  Dir  Fields (tdata / tuser, lowest bit first)
// s_*      in   tdata: key[30:0], value[62:31], pad[63]; tuser: kind
// m_*      out  tdata: found_value[31:0], slot[35:32], pad[39:36]; tuser: status
//
// Front hashes one word at a time (hash multiply, key mod slots 4 bits/cycle).
// Back: one key RAM read per cycle while probing; an insert reads up
// to TABLE_SLOTS+1 slots, a lookup up to max_probe+2; full/zero-key words read none.
// After reset every key RAM slot is cleared while s_tready is held low.
// A two-entry queue lets the front keep hashing while the back or m_* stalls.
module hash_table_quadratic_probe_top #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,   // kind
	input  logic [63:0] s_tdata,   // key, value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [2:0]  m_tuser,   // status
	output logic [39:0] m_tdata    // found_value, slot
);

	localparam int SW = $clog2(TABLE_SLOTS);
	localparam int QW = 2*SW + 65;

	logic          clearing;
	logic          push_valid;
	logic          push_ready;
	logic [QW-1:0] push_data;
	logic          q_valid;
	logic          q_pop;
	logic [QW-1:0] q_data;
	hqp_pkg::res_t m_res;

	hqp_front #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold       (clearing),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	hqp_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_data)
	);

	hqp_back #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_data   (q_data),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.m_res    (m_res)
	);

	assign m_tuser = m_res.status;
	assign m_tdata = {4'b0, m_res.slot, m_res.found_value};

endmodule
